// ----- sv/qea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qea_pkg: shared types and constants for the quaternion to Euler converter
// Opcodes, job codes, command and status bundles, fixed-point constants.
// ----------------------------------------------------------------------------
package qea_pkg;

   localparam int REQ_W = 128;
   localparam int RSP_W = 96;

   localparam int CW  = 38;   // direction cosine terms, Q.30
   localparam int AW  = 40;   // angles, Q.30
   localparam int NW  = 37;   // atan2 operand magnitudes
   localparam int RW  = 62;   // square root working width
   localparam int IDX_W = 5;
   localparam int OP_W  = 5;

   localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
   localparam logic [OP_W-1:0] OP_PMUL   = 5'd2;
   localparam logic [OP_W-1:0] OP_PSTO   = 5'd3;
   localparam logic [OP_W-1:0] OP_PCLAMP = 5'd4;
   localparam logic [OP_W-1:0] OP_SQMUL  = 5'd5;
   localparam logic [OP_W-1:0] OP_SQINIT = 5'd6;
   localparam logic [OP_W-1:0] OP_SQSTEP = 5'd7;
   localparam logic [OP_W-1:0] OP_ALOAD  = 5'd8;
   localparam logic [OP_W-1:0] OP_ANORM  = 5'd9;
   localparam logic [OP_W-1:0] OP_ADIV   = 5'd10;
   localparam logic [OP_W-1:0] OP_T2MUL  = 5'd11;
   localparam logic [OP_W-1:0] OP_T2W    = 5'd12;
   localparam logic [OP_W-1:0] OP_HMUL   = 5'd13;
   localparam logic [OP_W-1:0] OP_HW     = 5'd14;
   localparam logic [OP_W-1:0] OP_FMUL   = 5'd15;
   localparam logic [OP_W-1:0] OP_FW     = 5'd16;
   localparam logic [OP_W-1:0] OP_POST   = 5'd17;
   localparam logic [OP_W-1:0] OP_EMIT   = 5'd18;

   localparam logic [1:0] JOB_PITCH = 2'd0;
   localparam logic [1:0] JOB_ROLL  = 2'd1;
   localparam logic [1:0] JOB_YAW   = 2'd2;

   localparam logic [IDX_W-1:0] N_PROD_LAST = 5'd9;
   localparam logic [IDX_W-1:0] SQ_LAST     = 5'd30;
   localparam logic [IDX_W-1:0] DIV_LAST    = 5'd30;
   localparam logic [IDX_W-1:0] HORNER_LAST = 5'd4;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic [1:0]       job;
   } cmd_type;

   typedef struct packed {
      logic clamp;
      logic lock;
      logic zero;
      logic d_big;
      logic out_full;
   } sts_type;

   localparam logic signed [AW-1:0] PI_Q30   = 40'sd3373259426;
   localparam logic signed [AW-1:0] HPI_Q30  = 40'sd1686629713;
   localparam logic signed [CW-1:0] LOCK_Q30 = 38'sd1070520598;
   localparam logic signed [CW-1:0] ONE_Q30  = 38'sd1073741824;
   localparam logic signed [AW-1:0] ANG_MAX  = 40'sd843314857;
   localparam logic signed [AW-1:0] PIT_MAX  = 40'sd421657428;
   localparam logic signed [31:0]   A11      = -32'sd12585523;

   // Horner coefficients after the leading one, highest power first
   function automatic logic signed [31:0] horner_coef(input logic [2:0] k);
      logic signed [31:0] c;
      case (k)
         3'd0:    c = 32'sd56536072;
         3'd1:    c = -32'sd125018843;
         3'd2:    c = 32'sd207815708;
         3'd3:    c = -32'sd357151731;
         default: c = 32'sd1073717407;
      endcase
      return c;
   endfunction

   // Component pairs for the ten products p00..p33
   function automatic logic [1:0] pair_a(input logic [3:0] k);
      logic [1:0] a;
      case (k)
         4'd0, 4'd1, 4'd2, 4'd3: a = 2'd0;
         4'd4, 4'd5, 4'd6:       a = 2'd1;
         4'd7, 4'd8:             a = 2'd2;
         default:                a = 2'd3;
      endcase
      return a;
   endfunction

   function automatic logic [1:0] pair_b(input logic [3:0] k);
      logic [1:0] b;
      case (k)
         4'd0:                   b = 2'd0;
         4'd1, 4'd4:             b = 2'd1;
         4'd2, 4'd5, 4'd7:       b = 2'd2;
         default:                b = 2'd3;
      endcase
      return b;
   endfunction

   localparam int P00 = 0;
   localparam int P01 = 1;
   localparam int P02 = 2;
   localparam int P03 = 3;
   localparam int P11 = 4;
   localparam int P12 = 5;
   localparam int P13 = 6;
   localparam int P22 = 7;
   localparam int P23 = 8;
   localparam int P33 = 9;

endpackage

// ----- sv/qea_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qea_ctrl: sequencer for the quaternion to Euler converter
// Steps the datapath through products, square root and up to three atan2 passes.
// ----------------------------------------------------------------------------
module qea_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  qea_pkg::sts_type  sts,
   output qea_pkg::cmd_type  cmd
);
   import qea_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_PMUL   = 5'd1;
   localparam logic [4:0] S_PSTO   = 5'd2;
   localparam logic [4:0] S_PCHK   = 5'd3;
   localparam logic [4:0] S_SQMUL  = 5'd4;
   localparam logic [4:0] S_SQINIT = 5'd5;
   localparam logic [4:0] S_SQSTEP = 5'd6;
   localparam logic [4:0] S_ALOAD  = 5'd7;
   localparam logic [4:0] S_ANORM  = 5'd8;
   localparam logic [4:0] S_ADIV   = 5'd9;
   localparam logic [4:0] S_T2MUL  = 5'd10;
   localparam logic [4:0] S_T2W    = 5'd11;
   localparam logic [4:0] S_HMUL   = 5'd12;
   localparam logic [4:0] S_HW     = 5'd13;
   localparam logic [4:0] S_FMUL   = 5'd14;
   localparam logic [4:0] S_FW     = 5'd15;
   localparam logic [4:0] S_POST   = 5'd16;
   localparam logic [4:0] S_EMIT   = 5'd17;

   logic [4:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       job_ff, job_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      job_in   = job_ff;
      cmd.op   = OP_NOP;
      cmd.idx  = idx_ff;
      cmd.job  = job_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.op = OP_LOAD;
            if (req_tvalid) begin
               idx_in   = '0;
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            cmd.op   = OP_PMUL;
            state_in = S_PSTO;
         end
         S_PSTO: begin
            cmd.op = OP_PSTO;
            if (idx_ff == N_PROD_LAST) begin
               state_in = S_PCHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PMUL;
            end
         end
         S_PCHK: begin
            cmd.op = OP_PCLAMP;
            if (sts.clamp) begin
               job_in   = JOB_ROLL;
               state_in = S_ALOAD;
            end else begin
               state_in = S_SQMUL;
            end
         end
         S_SQMUL: begin
            cmd.op   = OP_SQMUL;
            state_in = S_SQINIT;
         end
         S_SQINIT: begin
            cmd.op   = OP_SQINIT;
            idx_in   = '0;
            state_in = S_SQSTEP;
         end
         S_SQSTEP: begin
            cmd.op = OP_SQSTEP;
            if (idx_ff == SQ_LAST) begin
               job_in   = JOB_PITCH;
               state_in = S_ALOAD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ALOAD: begin
            cmd.op   = OP_ALOAD;
            state_in = sts.zero ? S_POST : S_ANORM;
         end
         S_ANORM: begin
            cmd.op = OP_ANORM;
            if (!sts.d_big) begin
               idx_in   = '0;
               state_in = S_ADIV;
            end
         end
         S_ADIV: begin
            cmd.op = OP_ADIV;
            if (idx_ff == DIV_LAST) begin
               state_in = S_T2MUL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_T2MUL: begin
            cmd.op   = OP_T2MUL;
            state_in = S_T2W;
         end
         S_T2W: begin
            cmd.op   = OP_T2W;
            idx_in   = '0;
            state_in = S_HMUL;
         end
         S_HMUL: begin
            cmd.op   = OP_HMUL;
            state_in = S_HW;
         end
         S_HW: begin
            cmd.op = OP_HW;
            if (idx_ff == HORNER_LAST) begin
               state_in = S_FMUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_HMUL;
            end
         end
         S_FMUL: begin
            cmd.op   = OP_FMUL;
            state_in = S_FW;
         end
         S_FW: begin
            cmd.op   = OP_FW;
            state_in = S_POST;
         end
         S_POST: begin
            cmd.op = OP_POST;
            case (job_ff)
               JOB_PITCH: begin
                  job_in   = JOB_ROLL;
                  state_in = S_ALOAD;
               end
               JOB_ROLL: begin
                  if (sts.lock) begin
                     state_in = S_EMIT;
                  end else begin
                     job_in   = JOB_YAW;
                     state_in = S_ALOAD;
                  end
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!sts.out_full) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         job_ff   <= JOB_PITCH;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         job_ff   <= job_in;
      end
   end

endmodule

// ----- sv/qea_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qea_dpath: datapath of the quaternion to Euler converter
// Shared multiplier, bit-serial square root and divider, Horner polynomial.
// ----------------------------------------------------------------------------
module qea_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  qea_pkg::cmd_type            cmd,
   output qea_pkg::sts_type            sts,
   input  logic [qea_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        csr_wen,
   input  logic                        csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [qea_pkg::RSP_W-1:0]   rsp_tdata
);
   import qea_pkg::*;

   function automatic logic signed [AW-1:0] to_q28(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] lim);
      logic signed [AW-1:0] s;
      s = (a + AW'(2)) >>> 2;
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      return s;
   endfunction

   logic                     frame_mode_ff;
   logic signed [31:0]       held_ff;
   logic signed [31:0]       q_ff [4];
   logic signed [33:0]       p_ff [10];
   logic signed [65:0]       prod_ff;
   logic [RW-1:0]            rad_ff, res_ff, bit_ff;
   logic                     xneg_ff, yneg_ff, swap_ff;
   logic [NW-1:0]            n_ff, d_ff;
   logic [34:0]              rem_ff;
   logic [30:0]              quo_ff;
   logic signed [31:0]       t_ff, t2_ff, acc_ff;
   logic signed [AW-1:0]     ang_ff, pitch_ff, roll_ff, yaw_ff;
   logic                     rsp_valid_ff;
   logic [RSP_W-1:0]         rsp_data_ff;

   logic signed [CW-1:0] e [10];
   logic signed [CW-1:0] c11, c12, c22, c13, c31, c32, c33, yaw_y0, v, larg;
   logic                 lock_pos, lock_neg, lock;
   logic signed [CW-1:0] op_y, op_x;
   logic [NW-1:0]        ax, ay;
   logic signed [32:0]   ma, mb;
   logic signed [35:0]   prod_sh;
   logic [RW-1:0]        trial;
   logic [34:0]          dd, rn;
   logic                 ge;
   logic signed [31:0]   t_cur;
   logic signed [AW-1:0] r0, r1, r2, held4, roll_lk, roll_w1, roll_w2;
   logic signed [AW-1:0] rsat, psat, ysat;

   // cosine terms from the stored products
   always_comb begin
      for (int i = 0; i < 10; i++) begin
         e[i] = CW'(p_ff[i]);
      end
      c11    = e[P00] + e[P11] - e[P22] - e[P33];
      c12    = (e[P12] - e[P03]) <<< 1;
      c22    = e[P00] - e[P11] + e[P22] - e[P33];
      c13    = (e[P13] + e[P02]) <<< 1;
      c31    = (e[P13] - e[P02]) <<< 1;
      c32    = (e[P23] + e[P01]) <<< 1;
      c33    = e[P00] - e[P11] - e[P22] + e[P33];
      yaw_y0 = (e[P12] + e[P03]) <<< 1;
      v      = frame_mode_ff ? c32 : -c31;
      larg   = frame_mode_ff ? c32 : c31;
   end

   assign lock_pos = larg > LOCK_Q30;
   assign lock_neg = larg < -LOCK_Q30;
   assign lock     = lock_pos | lock_neg;

   // atan2 operand select
   always_comb begin
      op_y = c12;
      op_x = c22;
      case (cmd.job)
         JOB_PITCH: begin
            op_y = v;
            op_x = CW'(res_ff[30:0]);
         end
         JOB_ROLL: begin
            if (!frame_mode_ff) begin
               if (lock_pos) begin
                  op_y = -c12;
                  op_x = c22;
               end else if (lock_neg) begin
                  op_y = c12;
                  op_x = c22;
               end else begin
                  op_y = c32;
                  op_x = c33;
               end
            end else begin
               if (lock) begin
                  op_y = c13;
                  op_x = c11;
               end else begin
                  op_y = c31;
                  op_x = c33;
               end
            end
         end
         default: begin
            if (!frame_mode_ff) begin
               op_y = yaw_y0;
               op_x = c11;
            end else begin
               op_y = c12;
               op_x = c22;
            end
         end
      endcase
   end

   assign ax = NW'(op_x < 0 ? -op_x : op_x);
   assign ay = NW'(op_y < 0 ? -op_y : op_y);

   assign t_cur = (xneg_ff ^ yneg_ff) ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});

   // shared multiplier operands
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         OP_PMUL: begin
            ma = 33'(q_ff[pair_a(cmd.idx[3:0])]);
            mb = 33'(q_ff[pair_b(cmd.idx[3:0])]);
         end
         OP_SQMUL: begin
            ma = signed'(v[32:0]);
            mb = signed'(v[32:0]);
         end
         OP_T2MUL: begin
            ma = 33'(t_cur);
            mb = 33'(t_cur);
         end
         OP_HMUL: begin
            ma = 33'(t2_ff);
            mb = 33'(acc_ff);
         end
         OP_FMUL: begin
            ma = 33'(t_ff);
            mb = 33'(acc_ff);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign prod_sh = prod_ff[65:30];
   assign trial   = res_ff + bit_ff;
   assign dd      = 35'(d_ff[32:0]);
   assign ge      = rem_ff >= dd;
   assign rn      = ge ? rem_ff - dd : rem_ff;

   // quadrant correction of the polynomial result
   always_comb begin
      r0 = AW'(prod_sh);
      r1 = swap_ff ? (((xneg_ff == yneg_ff) ? HPI_Q30 : -HPI_Q30) - r0) : r0;
      r2 = xneg_ff ? (r1 + (yneg_ff ? -PI_Q30 : PI_Q30)) : r1;
   end

   // roll under gimbal lock: offset by the held yaw and wrap once
   always_comb begin
      held4   = AW'(held_ff) <<< 2;
      roll_lk = lock_pos ? ang_ff - held4 : ang_ff + held4;
      roll_w1 = (roll_lk > PI_Q30) ? roll_lk - (PI_Q30 <<< 1) : roll_lk;
      roll_w2 = (roll_w1 < -PI_Q30) ? roll_w1 + (PI_Q30 <<< 1) : roll_w1;
   end

   assign rsat = to_q28(roll_ff, ANG_MAX);
   assign psat = to_q28(pitch_ff, PIT_MAX);
   assign ysat = to_q28(yaw_ff, ANG_MAX);

   assign sts.clamp    = (v >= ONE_Q30) || (v <= -ONE_Q30);
   assign sts.lock     = lock;
   assign sts.zero     = (ax == '0) && (ay == '0);
   assign sts.d_big    = d_ff[NW-1:33] != '0;
   assign sts.out_full = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            q_ff[0] <= req_tdata[31:0];
            q_ff[1] <= req_tdata[63:32];
            q_ff[2] <= req_tdata[95:64];
            q_ff[3] <= req_tdata[127:96];
         end
         OP_PMUL, OP_SQMUL, OP_HMUL, OP_FMUL: prod_ff <= ma * mb;
         OP_T2MUL: begin
            prod_ff <= ma * mb;
            t_ff    <= t_cur;
         end
         OP_PSTO:   p_ff[cmd.idx[3:0]] <= prod_sh[33:0];
         OP_PCLAMP: pitch_ff <= (v > 0) ? HPI_Q30 : -HPI_Q30;
         OP_SQINIT: begin
            rad_ff <= (RW'(1) << 60) - RW'(prod_ff[59:0]);
            res_ff <= '0;
            bit_ff <= RW'(1) << 60;
         end
         OP_SQSTEP: begin
            if (rad_ff >= trial) begin
               rad_ff <= rad_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_ALOAD: begin
            swap_ff <= ax < ay;
            n_ff    <= (ax < ay) ? ax : ay;
            d_ff    <= (ax < ay) ? ay : ax;
            xneg_ff <= op_x < 0;
            yneg_ff <= op_y < 0;
            ang_ff  <= '0;
         end
         OP_ANORM: begin
            if (d_ff[NW-1:33] != '0) begin
               n_ff <= n_ff >> 1;
               d_ff <= d_ff >> 1;
            end else begin
               rem_ff <= 35'(n_ff[32:0]);
               quo_ff <= '0;
            end
         end
         OP_ADIV: begin
            rem_ff <= {rn[33:0], 1'b0};
            quo_ff <= {quo_ff[29:0], ge};
         end
         OP_T2W: begin
            t2_ff  <= prod_sh[31:0];
            acc_ff <= A11;
         end
         OP_HW: acc_ff <= 32'(36'(horner_coef(cmd.idx[2:0])) + prod_sh);
         OP_FW: ang_ff <= r2;
         OP_POST: begin
            case (cmd.job)
               JOB_PITCH: pitch_ff <= ang_ff;
               JOB_ROLL: begin
                  if (lock) roll_ff <= roll_w2;
                  else      roll_ff <= frame_mode_ff ? -ang_ff : ang_ff;
               end
               default: yaw_ff <= frame_mode_ff ? -ang_ff : ang_ff;
            endcase
         end
         OP_EMIT: begin
            rsp_data_ff <= {4'b0,
                            lock ? held_ff[30:0] : ysat[30:0],
                            psat[29:0],
                            rsat[30:0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= 1'b1;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) frame_mode_ff <= csr_wdata;
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
            if (!lock) held_ff <= 32'(ysat);
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- sv/quaternion_to_euler_angles.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: attitude quaternion to roll, pitch and yaw
// Fixed-point conversion with polynomial atan2 and asin, gimbal lock hold.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat carries a quaternion w, x, y, z in signed Q2.30.
//   rsp channel: one beat carries roll and yaw in signed Q3.28 and pitch in signed Q2.28 radians.
//   csr port: csr_wen with csr_wdata selects the frame formulas
//   (0 = NED/NWU, 1 = ENU); write it only while no beat is in flight.
// Pacing:
//   one beat is worked at a time; req_tready returns in the same cycle
//   that rsp_tvalid rises.
//   The work is paced by one shared 33x33 multiplier (ten products and the
//   polynomial), a 31-step square root and up to three atan2 passes, each
//   with a 31-step restoring divider.
// Reset: synchronous, active high; frame mode returns to ENU and the held
//   yaw clears to zero.
// Stall: a finished result waits in the output register; the next request
//   is accepted and worked meanwhile, and its result holds until the
//   output register has been taken.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [qea_pkg::REQ_W-1:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [qea_pkg::RSP_W-1:0] rsp_tdata,   // roll_angle, pitch_angle, yaw_angle
   input  logic                      csr_wen,
   input  logic                      csr_wdata    // frame_mode
);
   import qea_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: owns the request handshake and all step counting
   qea_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: arithmetic, held yaw, frame mode and the output register
   qea_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sim/euler_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_checker: scoreboard for the quaternion to Euler angle converter
// Watches the req, rsp and csr ports, predicts roll, pitch and yaw per
// accepted quaternion and compares each result beat field by field.
// ----------------------------------------------------------------------------
module euler_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [qea_pkg::REQ_W-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [qea_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_wen,
   input  logic                      csr_wdata,
   output int                        error_count,
   output int                        angles_pending
);

   localparam longint PI_FX   = 64'sd3373259426;
   localparam longint HPI_FX  = 64'sd1686629713;
   localparam longint LOCK_FX = 64'sd1070520598;
   localparam longint ROLL_LIM  = 64'sd843314857;
   localparam longint PITCH_LIM = 64'sd421657428;

   typedef struct {
      longint roll;
      longint pitch;
      longint yaw;
   } angle_set_type;

   angle_set_type angle_queue[$];
   logic          mode_enu;
   longint        last_yaw;

   assign angles_pending = angle_queue.size();

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_series(longint t);
      longint t2, acc;
      t2  = floor_shr(t * t, 30);
      acc = -64'sd12585523;
      acc = 64'sd56536072 + floor_shr(t2 * acc, 30);
      acc = -64'sd125018843 + floor_shr(t2 * acc, 30);
      acc = 64'sd207815708 + floor_shr(t2 * acc, 30);
      acc = -64'sd357151731 + floor_shr(t2 * acc, 30);
      acc = 64'sd1073717407 + floor_shr(t2 * acc, 30);
      return floor_shr(t * acc, 30);
   endfunction

   function automatic longint arc_tan2(longint y, longint x);
      longint unsigned ax, ay, n, d;
      longint t, r;
      bit swap;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ax == 0 && ay == 0) return 0;
      swap = ax < ay;
      n = swap ? ax : ay;
      d = swap ? ay : ax;
      while (d >= (64'd1 << 33)) begin
         n = n >> 1;
         d = d >> 1;
      end
      t = longint'((n << 30) / d);
      if ((x < 0) != (y < 0)) t = -t;
      r = atan_series(t);
      if (swap) r = (((x >= 0) == (y >= 0)) ? HPI_FX : -HPI_FX) - r;
      if (x < 0) r += (y >= 0) ? PI_FX : -PI_FX;
      return r;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint arc_sin(longint v);
      if (v >= (64'sd1 <<< 30)) return HPI_FX;
      if (v <= -(64'sd1 <<< 30)) return -HPI_FX;
      return arc_tan2(v, longint'(floor_sqrt((64'd1 << 60) - longint'(v * v))));
   endfunction

   function automatic longint to_radians_q28(longint a, longint lim);
      longint r;
      r = floor_shr(a + 2, 2);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint wrap_half_turn(longint a);
      if (a > PI_FX) a -= 2 * PI_FX;
      if (a < -PI_FX) a += 2 * PI_FX;
      return a;
   endfunction

   // Predict one result; updates the held yaw when not in gimbal lock.
   function automatic angle_set_type predict_angles(logic [127:0] q);
      longint w, x, y, z;
      longint p00, p01, p02, p03, p11, p12, p13, p22, p23, p33;
      longint c11, c12, c22, c13, c31, c32, held, roll, pitch, yaw;
      bit locked;
      angle_set_type a;
      w = longint'($signed(q[31:0]));
      x = longint'($signed(q[63:32]));
      y = longint'($signed(q[95:64]));
      z = longint'($signed(q[127:96]));
      p00 = floor_shr(w * w, 30); p01 = floor_shr(w * x, 30);
      p02 = floor_shr(w * y, 30); p03 = floor_shr(w * z, 30);
      p11 = floor_shr(x * x, 30); p12 = floor_shr(x * y, 30);
      p13 = floor_shr(x * z, 30); p22 = floor_shr(y * y, 30);
      p23 = floor_shr(y * z, 30); p33 = floor_shr(z * z, 30);
      c11 = p00 + p11 - p22 - p33;
      c12 = 2 * (p12 - p03);
      c22 = p00 - p11 + p22 - p33;
      c13 = 2 * (p13 + p02);
      c31 = 2 * (p13 - p02);
      c32 = 2 * (p23 + p01);
      held = last_yaw * 4;
      locked = 1;
      yaw = 0;
      if (!mode_enu) begin
         pitch = arc_sin(2 * (p02 - p13));
         if (c31 > LOCK_FX) roll = wrap_half_turn(arc_tan2(-c12, c22) - held);
         else if (c31 < -LOCK_FX) roll = wrap_half_turn(arc_tan2(c12, c22) + held);
         else begin
            locked = 0;
            roll = arc_tan2(c32, p00 - p11 - p22 + p33);
            yaw  = arc_tan2(2 * (p12 + p03), c11);
         end
      end else begin
         pitch = arc_sin(c32);
         if (c32 > LOCK_FX) roll = wrap_half_turn(arc_tan2(c13, c11) - held);
         else if (c32 < -LOCK_FX) roll = wrap_half_turn(arc_tan2(c13, c11) + held);
         else begin
            locked = 0;
            roll = -arc_tan2(c31, p00 - p11 - p22 + p33);
            yaw  = -arc_tan2(c12, c22);
         end
      end
      a.roll  = to_radians_q28(roll, ROLL_LIM);
      a.pitch = to_radians_q28(pitch, PITCH_LIM);
      if (locked) a.yaw = last_yaw;
      else begin
         a.yaw = to_radians_q28(yaw, ROLL_LIM);
         last_yaw = a.yaw;
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      angle_set_type want;
      longint got_roll, got_pitch, got_yaw;
      if (reset) begin
         mode_enu    <= 1'b1;
         last_yaw    = 0;
         error_count = 0;
         angle_queue.delete();
      end else begin
         if (csr_wen) mode_enu <= csr_wdata;
         if (req_tvalid && req_tready) angle_queue.push_back(predict_angles(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_roll  = longint'($signed(rsp_tdata[30:0]));
            got_pitch = longint'($signed(rsp_tdata[60:31]));
            got_yaw   = longint'($signed(rsp_tdata[91:61]));
            if (angle_queue.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               want = angle_queue.pop_front();
               if (got_roll != want.roll) report_mismatch("roll", got_roll, want.roll);
               if (got_pitch != want.pitch)
                  report_mismatch("pitch", got_pitch, want.pitch);
               if (got_yaw != want.yaw) report_mismatch("yaw", got_yaw, want.yaw);
            end
         end
      end
   end

endmodule

// ----- sim/tb_quaternion_to_euler_angles.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles: regression bench for the Euler converter
// Drives directed and random quaternions in both frame modes under random
// idling on both sides; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
   import qea_pkg::*;

   localparam logic FRAME_NED = 1'b0;
   localparam logic FRAME_ENU = 1'b1;
   localparam int   ONE_FX    = 1 << 30;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_wen;
   logic             csr_wdata;
   int               error_count;
   int               angles_pending;
   bit               calm_phase;

   quaternion_to_euler_angles dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   euler_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .error_count(error_count), .angles_pending(angles_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random roughly 23 percent, never during the calm phase.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm_phase || ($urandom_range(99) >= 23);
   end

   // Send one quaternion beat; idle random cycles first unless calm.
   // Valid stays high after the beat is taken until the next idle or drain.
   task automatic send_quat(int w, int x, int y, int z);
      while (!calm_phase && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold until every expected beat has arrived, then let the block settle.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_frame(logic mode);
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   // Random quaternion: mostly components within plus or minus one half, some near gimbal lock, some raw noise.
   task automatic send_random_quat();
      int sel, a, b, s;
      sel = $urandom_range(99);
      a = $urandom_range(ONE_FX) - ONE_FX / 2;
      b = $urandom_range(ONE_FX) - ONE_FX / 2;
      if (sel < 20) begin
         send_quat($urandom, $urandom, $urandom, $urandom);
      end else if (sel < 40) begin
         // w and a vector pair near 0.707 push the sine term toward one
         s = 759250124 + int'($urandom_range(4000000)) - 2000000;
         case ($urandom_range(3))
            0: send_quat(s, s, a >>> 6, b >>> 6);
            1: send_quat(s, -s, a >>> 6, b >>> 6);
            2: send_quat(s, a >>> 6, s, b >>> 6);
            default: send_quat(s, a >>> 6, -s, b >>> 6);
         endcase
      end else begin
         send_quat(a, b, $urandom_range(ONE_FX) - ONE_FX / 2,
                   $urandom_range(ONE_FX) - ONE_FX / 2);
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = 1'b0;
      calm_phase = 1'b0;
      reset      = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int pass = 0; pass < 2; pass++) begin
         // Reset leaves ENU; the second pass exercises NED/NWU
         if (pass == 1) write_frame(FRAME_NED);
         send_quat(ONE_FX, 0, 0, 0);
         send_quat(0, 0, 0, 0);                      // both atan2 operands zero
         send_quat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
         send_quat(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
         send_quat(32'h80000000, 32'h7fffffff, 0, 32'h80000000);
         send_quat(0, ONE_FX, 0, 0);
         send_quat(0, 0, ONE_FX, 0);
         send_quat(0, 0, 0, ONE_FX);
         send_quat(759250125, 759250125, 0, 0);       // ENU lock, positive
         send_quat(759250125, -759250125, 0, 0);      // ENU lock, negative
         send_quat(759250125, 0, 759250125, 0);       // NED lock
         send_quat(759250125, 0, -759250125, 0);
         send_quat(600000000, 500000000, 400000000, 300000000);
         send_quat(-ONE_FX / 2, ONE_FX / 3, -ONE_FX / 5, ONE_FX / 7);
         drain_block();
      end

      // Random part: alternate frames, extremes included, calm stretch midway
      for (int i = 0; i < 450; i++) begin
         if (i % 90 == 0) begin
            drain_block();
            write_frame((i / 90) % 2 == 0 ? FRAME_ENU : FRAME_NED);
         end
         calm_phase = (i >= 200 && i < 260);
         send_random_quat();
      end
      calm_phase = 1'b0;

      drain_block();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
